@@ sv/gnpm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnpm_pkg
// Shared types and constants of the greedy nearest-point matcher.
// ----------------------------------------------------------------------------
package gnpm_pkg;

    localparam int MAX_REFS_DEF = 64;

    localparam int COORD_W     = 24;
    localparam int RADIUS_W    = 23;
    localparam int LIMIT_W     = 2 * RADIUS_W;
    localparam int KIND_W      = 2;
    localparam int REF_INDEX_W = 6;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(4096);

    // distance pipeline widths: |difference|, square, sum of three squares
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 2;

    // cycles from the last point fed to the distance pipeline until its best is final
    localparam int DRAIN_CYC = 3;
    localparam int DRAIN_W   = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } t_state;

    typedef logic [COORD_W-1:0] t_coord;

    // x in the lowest bits
    typedef struct packed {
        t_coord z;
        t_coord y;
        t_coord x;
    } t_point;

    typedef struct packed {
        logic   live;
        t_point pt;
    } t_ref_entry;

    typedef struct packed {
        logic shift;
        logic clear;
        logic load;
        logic claim;
    } t_cell_ctl;

    // matched in the lowest bit
    typedef struct packed {
        logic                   table_full;
        logic [REF_INDEX_W-1:0] ref_index;
        logic                   matched;
    } t_result;

endpackage
`default_nettype wire

@@ sv/gnpm_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnpm_cell
// One slot of the reference ring: a stored point and its unclaimed flag.
// ----------------------------------------------------------------------------
module gnpm_cell (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  gnpm_pkg::t_cell_ctl   i_ctl,
    input  gnpm_pkg::t_ref_entry  i_next,
    input  gnpm_pkg::t_point      i_load_pt,
    output gnpm_pkg::t_ref_entry  o_entry
);

    logic             r_live;
    gnpm_pkg::t_point r_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            priority if (i_ctl.clear) begin
                r_live <= 1'b0;
            end else if (i_ctl.shift) begin
                r_live <= i_next.live;
            end else if (i_ctl.load) begin
                r_live <= 1'b1;
            end else if (i_ctl.claim) begin
                r_live <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_pt <= i_next.pt;
        end else if (i_ctl.load) begin
            r_pt <= i_load_pt;
        end
    end

    assign o_entry.live = r_live;
    assign o_entry.pt   = r_pt;

endmodule
`default_nettype wire

@@ sv/gnpm_dist.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnpm_dist
// Squared-distance pipeline at the head of the ring with running minimum.
// ----------------------------------------------------------------------------
module gnpm_dist #(
    parameter int IDX_W = 6
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire                           i_valid,
    input  wire  [IDX_W-1:0]              i_idx,
    input  gnpm_pkg::t_point              i_ref,
    input  gnpm_pkg::t_point              i_query,
    output logic                          o_found,
    output logic [gnpm_pkg::SUM_W-1:0]    o_best,
    output logic [IDX_W-1:0]              o_best_idx
);

    localparam int DW = gnpm_pkg::DIFF_W;
    localparam int QW = gnpm_pkg::SQ_W;
    localparam int SW = gnpm_pkg::SUM_W;

    logic [DW-1:0] w_dx, w_dy, w_dz;
    logic [DW-1:0] r_mx, r_my, r_mz;
    logic [QW-1:0] r_sx, r_sy, r_sz;
    logic [SW-1:0] r_sum;
    logic          r_v1, r_v2, r_v3;
    logic [IDX_W-1:0] r_i1, r_i2, r_i3;
    logic          r_found;
    logic [SW-1:0] r_best;
    logic [IDX_W-1:0] r_best_idx;

    function automatic logic [DW-1:0] abs_diff(input gnpm_pkg::t_coord a,
                                               input gnpm_pkg::t_coord b);
        logic [DW-1:0] d;
        d = {a[gnpm_pkg::COORD_W-1], a} - {b[gnpm_pkg::COORD_W-1], b};
        return d[DW-1] ? (~d + 1'b1) : d;
    endfunction

    assign w_dx = abs_diff(i_query.x, i_ref.x);
    assign w_dy = abs_diff(i_query.y, i_ref.y);
    assign w_dz = abs_diff(i_query.z, i_ref.z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx  <= w_dx;
        r_my  <= w_dy;
        r_mz  <= w_dz;
        r_i1  <= i_idx;
        r_sx  <= r_mx * r_mx;
        r_sy  <= r_my * r_my;
        r_sz  <= r_mz * r_mz;
        r_i2  <= r_i1;
        r_sum <= SW'(r_sx) + SW'(r_sy) + SW'(r_sz);
        r_i3  <= r_i2;
    end

    // strict compare keeps the lowest index on ties, points arrive in index order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_start) begin
            r_found <= 1'b0;
        end else if (r_v3 && (!r_found || r_sum < r_best)) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_start && r_v3 && (!r_found || r_sum < r_best)) begin
            r_best     <= r_sum;
            r_best_idx <= r_i3;
        end
    end

    assign o_found    = r_found;
    assign o_best     = r_best;
    assign o_best_idx = r_best_idx;

endmodule
`default_nettype wire

@@ sv/greedy_nearest_point_matcher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_nearest_point_matcher
// Greedy one-to-one association of query points with stored reference points.
// ----------------------------------------------------------------------------
// Reference points live in a ring of MAX_REFS cells. A query rotates the whole
// ring once past a four-stage squared-distance pipeline at its head: the query
// is accepted, the ring makes MAX_REFS rotation steps, the pipeline drains and
// the winner is decided and claimed. A new request is taken only in the idle
// state, once the output register is empty or its result leaves in that same
// cycle. The radius register may be written at any time the block is idle.
module greedy_nearest_point_matcher #(
    parameter int MAX_REFS = gnpm_pkg::MAX_REFS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration: match_radius
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [22:0] i_cfg_data,
    // requests
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [71:0] s_axis_tdata,   // x_coord, y_coord, z_coord
    input  wire  [1:0]  s_axis_tuser,   // kind
    // results
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata    // matched, ref_index, table_full
);

    localparam int IDX_W = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int CNT_W = $clog2(MAX_REFS + 1);

    gnpm_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_step, n_step;
    logic [gnpm_pkg::DRAIN_W-1:0] r_drain, n_drain;
    logic             r_out_valid, n_out_valid;
    gnpm_pkg::t_result r_out_data, n_out_data;
    logic [gnpm_pkg::RADIUS_W-1:0] r_radius;
    logic [gnpm_pkg::LIMIT_W-1:0]  r_limit;
    gnpm_pkg::t_point r_query;

    gnpm_pkg::t_point     w_in_pt;
    gnpm_pkg::t_kind      w_kind;
    logic                 w_accept;
    logic                 w_shift, w_clear, w_load, w_claim, w_start;
    logic                 w_match;
    logic                 w_found;
    logic [gnpm_pkg::SUM_W-1:0] w_best;
    logic [IDX_W-1:0]     w_best_idx;
    gnpm_pkg::t_ref_entry w_entry [MAX_REFS];
    logic [MAX_REFS-1:0]  w_live;

    assign w_in_pt  = gnpm_pkg::t_point'(s_axis_tdata);
    assign w_kind   = gnpm_pkg::t_kind'(s_axis_tuser);
    assign s_axis_tready = (r_state == gnpm_pkg::ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    assign w_match = w_found && (w_best < gnpm_pkg::SUM_W'(r_limit));

    // ring of cells; cell k takes from cell k+1 while rotating
    for (genvar k = 0; k < MAX_REFS; k++) begin : g_cell
        gnpm_pkg::t_cell_ctl w_ctl;
        assign w_ctl.shift = w_shift;
        assign w_ctl.clear = w_clear;
        assign w_ctl.load  = w_load && (r_count == CNT_W'(k));
        assign w_ctl.claim = w_claim && (w_best_idx == IDX_W'(k));
        assign w_live[k]   = w_entry[k].live;

        gnpm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_next    (w_entry[(k + 1) % MAX_REFS]),
            .i_load_pt (w_in_pt),
            .o_entry   (w_entry[k])
        );
    end

    gnpm_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_valid    ((r_state == gnpm_pkg::ST_SCAN) && w_entry[0].live),
        .i_idx      (r_step),
        .i_ref      (w_entry[0].pt),
        .i_query    (r_query),
        .o_found    (w_found),
        .o_best     (w_best),
        .o_best_idx (w_best_idx)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_drain     = r_drain;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        w_shift     = 1'b0;
        w_clear     = 1'b0;
        w_load      = 1'b0;
        w_claim     = 1'b0;
        w_start     = 1'b0;
        unique case (r_state)
            gnpm_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_kind)
                        gnpm_pkg::KIND_LOAD: begin
                            n_out_valid = 1'b1;
                            n_out_data  = '0;
                            if (r_count < CNT_W'(MAX_REFS)) begin
                                w_load  = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_out_data.table_full = 1'b1;
                            end
                        end
                        gnpm_pkg::KIND_QUERY: begin
                            w_start = 1'b1;
                            n_step  = '0;
                            n_state = gnpm_pkg::ST_SCAN;
                        end
                        gnpm_pkg::KIND_CLEAR: begin
                            w_clear = 1'b1;
                            n_count = '0;
                        end
                        default: begin
                            // drop unknown kinds
                        end
                    endcase
                end
            end
            gnpm_pkg::ST_SCAN: begin
                w_shift = 1'b1;
                n_step  = r_step + 1'b1;
                if (r_step == IDX_W'(MAX_REFS - 1)) begin
                    n_drain = '0;
                    n_state = gnpm_pkg::ST_DRAIN;
                end
            end
            gnpm_pkg::ST_DRAIN: begin
                n_drain = r_drain + 1'b1;
                if (r_drain == gnpm_pkg::DRAIN_W'(gnpm_pkg::DRAIN_CYC - 1)) begin
                    n_state = gnpm_pkg::ST_DECIDE;
                end
            end
            gnpm_pkg::ST_DECIDE: begin
                // ring is back home after a full rotation; claim the winner
                w_claim     = w_match;
                n_out_valid = 1'b1;
                n_out_data.matched    = w_match;
                n_out_data.ref_index  = w_match ? gnpm_pkg::REF_INDEX_W'(w_best_idx) : '0;
                n_out_data.table_full = 1'b0;
                n_state     = gnpm_pkg::ST_IDLE;
            end
            default: begin
                n_state = gnpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gnpm_pkg::ST_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
            r_radius    <= gnpm_pkg::RADIUS_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_radius <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (w_start) begin
            r_query <= w_in_pt;
            r_limit <= r_radius * r_radius;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_REFS))
        else $error("reference count beyond capacity");

    a_decide_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gnpm_pkg::ST_DECIDE) |-> !r_out_valid)
        else $error("query result would overwrite a pending result");

    a_match_is_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gnpm_pkg::ST_DECIDE && w_match) |-> w_live[w_best_idx])
        else $error("match points at a claimed or empty cell");

    a_claim_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gnpm_pkg::ST_DECIDE && w_match) |=> !w_live[$past(w_best_idx)])
        else $error("claimed reference still live");

endmodule
`default_nettype wire
